// ===== rtl/core/utf8dv_pkg.sv =====
// Shared types and constants for the UTF-8 stream decoder and validator.
package utf8dv_pkg;

   localparam int unsigned CpWidth  = 21;
   localparam int unsigned LenWidth = 3;

   localparam logic [CpWidth-1:0] CpMax      = 21'h10FFFF;
   localparam logic [CpWidth-1:0] SurrLo     = 21'h00D800;
   localparam logic [CpWidth-1:0] SurrHi     = 21'h00DFFF;
   localparam logic [CpWidth-1:0] MinLen2    = 21'h000080;
   localparam logic [CpWidth-1:0] MinLen3    = 21'h000800;
   localparam logic [CpWidth-1:0] MinLen4    = 21'h010000;
   localparam logic [CpWidth-1:0] AsciiLimit = 21'h000080;

   localparam logic [LenWidth-1:0] LenNone = 3'd0;
   localparam logic [LenWidth-1:0] LenOne  = 3'd1;
   localparam logic [LenWidth-1:0] LenTwo  = 3'd2;
   localparam logic [LenWidth-1:0] LenThree = 3'd3;
   localparam logic [LenWidth-1:0] LenFour = 3'd4;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_BAD_LEAD  = 3'd1,
      ST_BAD_CONT  = 3'd2,
      ST_TRUNC     = 3'd3,
      ST_OVERLONG  = 3'd4,
      ST_SURROGATE = 3'd5,
      ST_RANGE     = 3'd6,
      ST_DROPPED   = 3'd7
   } status_type;

endpackage

// ===== rtl/core/utf8_stream_decoder_validator.sv =====
// UTF-8 stream decoder and validator, one byte per transfer.
//
// Bytes of a string arrive one per req_ transfer, the final one flagged by
// req_last_in_string. A byte is taken in every cycle unless a result waits
// in the output register and rsp_stall is high; each byte's work is done
// combinationally between the sequence state and that register, so the
// sustained rate is one byte per clock. A finished sequence, any error and
// the last byte of a string give one result; bytes inside a sequence give
// none. After the first error the rest of the string is dropped and its last
// byte reports status "dropped after error" with string_valid low.
module utf8_stream_decoder_validator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_in_string,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [20:0] rsp_code_point,
   output logic [2:0]  rsp_seq_length,
   output logic [2:0]  rsp_status,
   output logic        rsp_end_of_string,
   output logic        rsp_string_valid
);

   logic [1:0]  bytes_left_ff, bytes_left_in;
   logic [2:0]  seq_total_ff, seq_total_in;
   logic [20:0] acc_ff, acc_in;
   logic        failed_ff, failed_in;

   logic                   rsp_valid_ff;
   logic [20:0]            cp_ff, cp_in;
   logic [2:0]             len_ff, len_in;
   utf8dv_pkg::status_type status_ff, status_in;
   logic                   eos_ff, eos_in;
   logic                   sv_ff, sv_in;

   logic        emit;
   logic        accept;
   logic [7:0]  b;
   logic        last;
   logic [2:0]  lead_len;
   logic [20:0] lead_bits;
   logic [20:0] acc_next;
   logic [1:0]  left_next;
   logic [20:0] min_cp;

   assign b         = req_data_byte;
   assign last      = req_last_in_string;
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign acc_next  = {acc_ff[14:0], b[5:0]};
   assign left_next = bytes_left_ff - 2'd1;

   always_comb begin
      priority if (b[7:5] == 3'b110) begin
         lead_len  = utf8dv_pkg::LenTwo;
         lead_bits = {16'd0, b[4:0]};
      end else if (b[7:4] == 4'b1110) begin
         lead_len  = utf8dv_pkg::LenThree;
         lead_bits = {17'd0, b[3:0]};
      end else if (b[7:3] == 5'b11110) begin
         lead_len  = utf8dv_pkg::LenFour;
         lead_bits = {18'd0, b[2:0]};
      end else begin
         lead_len  = utf8dv_pkg::LenNone;
         lead_bits = '0;
      end
   end

   always_comb begin
      unique case (seq_total_ff)
         utf8dv_pkg::LenTwo:   min_cp = utf8dv_pkg::MinLen2;
         utf8dv_pkg::LenThree: min_cp = utf8dv_pkg::MinLen3;
         default:              min_cp = utf8dv_pkg::MinLen4;
      endcase
   end

   always_comb begin
      bytes_left_in = bytes_left_ff;
      seq_total_in  = seq_total_ff;
      acc_in        = acc_ff;
      failed_in     = failed_ff;
      emit          = 1'b0;
      cp_in         = '0;
      len_in        = utf8dv_pkg::LenNone;
      status_in     = utf8dv_pkg::ST_OK;
      eos_in        = last;
      sv_in         = 1'b0;

      if (failed_ff) begin
         // drop bytes until the string closes
         if (last) begin
            failed_in = 1'b0;
            emit      = 1'b1;
            status_in = utf8dv_pkg::ST_DROPPED;
         end
      end else if (bytes_left_ff == 2'd0) begin
         if (!b[7]) begin
            emit   = 1'b1;
            cp_in  = {13'd0, b};
            len_in = utf8dv_pkg::LenOne;
            sv_in  = 1'b1;
         end else if (lead_len == utf8dv_pkg::LenNone) begin
            emit      = 1'b1;
            status_in = utf8dv_pkg::ST_BAD_LEAD;
         end else if (last) begin
            emit      = 1'b1;
            status_in = utf8dv_pkg::ST_TRUNC;
         end else begin
            acc_in        = lead_bits;
            seq_total_in  = lead_len;
            bytes_left_in = lead_len[1:0] - 2'd1;
         end
      end else if (b[7:6] != 2'b10) begin
         emit      = 1'b1;
         status_in = utf8dv_pkg::ST_BAD_CONT;
      end else if (left_next != 2'd0) begin
         if (last) begin
            emit      = 1'b1;
            status_in = utf8dv_pkg::ST_TRUNC;
         end else begin
            acc_in        = acc_next;
            bytes_left_in = left_next;
         end
      end else begin
         emit = 1'b1;
         priority if (acc_next > utf8dv_pkg::CpMax) begin
            status_in = utf8dv_pkg::ST_RANGE;
         end else if (acc_next >= utf8dv_pkg::SurrLo && acc_next <= utf8dv_pkg::SurrHi) begin
            status_in = utf8dv_pkg::ST_SURROGATE;
         end else if (acc_next < min_cp) begin
            status_in = utf8dv_pkg::ST_OVERLONG;
         end else begin
            cp_in  = acc_next;
            len_in = seq_total_ff;
            sv_in  = 1'b1;
         end
      end

      // any result closes the open sequence; an error before the last byte opens the drop phase
      if (emit) begin
         bytes_left_in = '0;
         seq_total_in  = '0;
         acc_in        = '0;
         if (status_in != utf8dv_pkg::ST_OK && status_in != utf8dv_pkg::ST_DROPPED) begin
            failed_in = !last;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_left_ff <= '0;
         seq_total_ff  <= '0;
         acc_ff        <= '0;
         failed_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (accept && emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (accept) begin
            bytes_left_ff <= bytes_left_in;
            seq_total_ff  <= seq_total_in;
            acc_ff        <= acc_in;
            failed_ff     <= failed_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         cp_ff     <= cp_in;
         len_ff    <= len_in;
         status_ff <= status_in;
         eos_ff    <= eos_in;
         sv_ff     <= sv_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_code_point    = cp_ff;
   assign rsp_seq_length    = len_ff;
   assign rsp_status        = status_ff;
   assign rsp_end_of_string = eos_ff;
   assign rsp_string_valid  = sv_ff;

endmodule

// ===== rtl/core/utf8dv_checker.sv =====
// Port-level checks for the UTF-8 stream decoder and validator, with bind.
module utf8dv_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [7:0]  req_data_byte,
   input logic        req_last_in_string,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [20:0] rsp_code_point,
   input logic [2:0]  rsp_seq_length,
   input logic [2:0]  rsp_status,
   input logic        rsp_end_of_string,
   input logic        rsp_string_valid
);

   // error results carry no code point, no length and a failed string
   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != utf8dv_pkg::ST_OK |->
         rsp_code_point == '0 && rsp_seq_length == utf8dv_pkg::LenNone && !rsp_string_valid)
      else $error("error result carries data");

   a_ok_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == utf8dv_pkg::ST_OK |->
         rsp_string_valid && rsp_seq_length != utf8dv_pkg::LenNone
         && rsp_seq_length <= utf8dv_pkg::LenFour && rsp_code_point <= utf8dv_pkg::CpMax)
      else $error("ok result out of shape");

   a_ascii: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == utf8dv_pkg::ST_OK && rsp_seq_length == utf8dv_pkg::LenOne
         |-> rsp_code_point < utf8dv_pkg::AsciiLimit)
      else $error("single byte result above ASCII");

   a_dropped_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == utf8dv_pkg::ST_DROPPED |-> rsp_end_of_string)
      else $error("dropped result does not close the string");

   // first edge out of reset shows no result
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind utf8_stream_decoder_validator utf8dv_checker u_utf8dv_checker (.*);

// ===== verif/utf8_stream_decoder_validator_tb.sv =====
// Self-checking testbench for the UTF-8 stream decoder and validator.
module utf8_stream_decoder_validator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic [7:0] octet_queue_type[$];

   typedef struct packed {
      logic [20:0]            cp;
      logic [2:0]             len;
      utf8dv_pkg::status_type st;
      logic                   eos;
      logic                   ok;
   } decode_result_type;

   // Tracks the decoder state per byte and holds the results still owed.
   class utf8_decode_check;
      bit [1:0]          cont_left;
      bit [2:0]          seq_len;
      bit [20:0]         gathered;
      bit                in_error;
      decode_result_type results_due[$];
      int                errors;
      int                checked;
      int                good_strings;

      function int pending();
         return results_due.size();
      endfunction

      // Every result closes the open sequence; an end-of-string result also
      // clears the error latch.
      function void push_result(logic [20:0] cp, logic [2:0] len,
                                utf8dv_pkg::status_type st, logic eos, logic ok);
         decode_result_type r;
         r.cp  = cp;
         r.len = len;
         r.st  = st;
         r.eos = eos;
         r.ok  = ok;
         results_due.insert(results_due.size(), r);
         cont_left = 2'd0;
         seq_len   = 3'd0;
         gathered  = 21'd0;
         if (eos) begin
            in_error = 1'b0;
         end
      endfunction

      function void reject(utf8dv_pkg::status_type st, logic last);
         push_result(21'd0, utf8dv_pkg::LenNone, st, last, 1'b0);
         in_error = !last;
      endfunction

      function void note_byte(logic [7:0] b, logic last);
         logic [2:0]  len;
         logic [20:0] minimum;
         if (in_error) begin
            if (last) begin
               push_result(21'd0, utf8dv_pkg::LenNone, utf8dv_pkg::ST_DROPPED, 1'b1, 1'b0);
            end
            return;
         end
         if (cont_left == 2'd0) begin
            if (b < 8'h80) begin
               push_result({13'd0, b}, utf8dv_pkg::LenOne, utf8dv_pkg::ST_OK, last, 1'b1);
               return;
            end
            len = utf8dv_pkg::LenNone;
            casez (b)
               8'b110?????: begin
                  len = utf8dv_pkg::LenTwo;
                  gathered = {16'd0, b[4:0]};
               end
               8'b1110????: begin
                  len = utf8dv_pkg::LenThree;
                  gathered = {17'd0, b[3:0]};
               end
               8'b11110???: begin
                  len = utf8dv_pkg::LenFour;
                  gathered = {18'd0, b[2:0]};
               end
               default: len = utf8dv_pkg::LenNone;
            endcase
            if (len == utf8dv_pkg::LenNone) begin
               reject(utf8dv_pkg::ST_BAD_LEAD, last);
               return;
            end
            seq_len   = len;
            cont_left = 2'(len - 3'd1);
            if (last) begin
               reject(utf8dv_pkg::ST_TRUNC, last);
            end
            return;
         end
         if (b[7:6] != 2'b10) begin
            reject(utf8dv_pkg::ST_BAD_CONT, last);
            return;
         end
         gathered  = {gathered[14:0], b[5:0]};
         cont_left = cont_left - 2'd1;
         if (cont_left != 2'd0) begin
            if (last) begin
               reject(utf8dv_pkg::ST_TRUNC, last);
            end
            return;
         end
         minimum = (seq_len == utf8dv_pkg::LenTwo) ? utf8dv_pkg::MinLen2 :
                   (seq_len == utf8dv_pkg::LenThree) ? utf8dv_pkg::MinLen3 :
                   utf8dv_pkg::MinLen4;
         // range beats surrogate beats overlong
         if (gathered > utf8dv_pkg::CpMax) begin
            reject(utf8dv_pkg::ST_RANGE, last);
         end else if (gathered >= utf8dv_pkg::SurrLo && gathered <= utf8dv_pkg::SurrHi) begin
            reject(utf8dv_pkg::ST_SURROGATE, last);
         end else if (gathered < minimum) begin
            reject(utf8dv_pkg::ST_OVERLONG, last);
         end else begin
            push_result(gathered, seq_len, utf8dv_pkg::ST_OK, last, 1'b1);
         end
      endfunction

      function void check_result(decode_result_type got);
         decode_result_type want;
         if (results_due.size() == 0) begin
            errors++;
            if (errors <= 10) begin
               $display("unexpected result: cp %h len %0d status %0d eos %0d valid %0d",
                        got.cp, got.len, got.st, got.eos, got.ok);
            end
            return;
         end
         want = results_due.pop_front();
         checked++;
         if (want.eos && want.ok) begin
            good_strings++;
         end
         if (got.cp !== want.cp || got.len !== want.len || got.st !== want.st ||
             got.eos !== want.eos || got.ok !== want.ok) begin
            errors++;
            if (errors <= 10) begin
               $display("mismatch exp/act: cp %h/%h len %0d/%0d st %0d/%0d eos %0d/%0d ok %0d/%0d",
                        want.cp, got.cp, want.len, got.len, want.st, got.st,
                        want.eos, got.eos, want.ok, got.ok);
            end
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_last_in_string = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [20:0] rsp_code_point;
   logic [2:0]  rsp_seq_length;
   logic [2:0]  rsp_status;
   logic        rsp_end_of_string;
   logic        rsp_string_valid;

   utf8_decode_check decoder_check = new();
   int idle_pct = 13;
   int bytes_sent = 0;
   int strings_sent = 0;

   utf8_stream_decoder_validator DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_last_in_string (req_last_in_string),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_code_point     (rsp_code_point),
      .rsp_seq_length     (rsp_seq_length),
      .rsp_status         (rsp_status),
      .rsp_end_of_string  (rsp_end_of_string),
      .rsp_string_valid   (rsp_string_valid)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < idle_pct);
   end

   // Note accepted bytes before checking results taken on the same edge.
   always @(posedge clock) begin
      decode_result_type got;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            decoder_check.note_byte(req_data_byte, req_last_in_string);
         end
         if (rsp_valid && !rsp_stall) begin
            got.cp  = rsp_code_point;
            got.len = rsp_seq_length;
            got.st  = utf8dv_pkg::status_type'(rsp_status);
            got.eos = rsp_end_of_string;
            got.ok  = rsp_string_valid;
            decoder_check.check_result(got);
         end
      end
   end

   task automatic send_byte(logic [7:0] b, logic last);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_data_byte      <= b;
      req_last_in_string <= last;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      bytes_sent++;
   endtask

   task automatic send_string(octet_queue_type s);
      for (int i = 0; i < s.size(); i++) begin
         send_byte(s[i], i == s.size() - 1);
      end
      strings_sent++;
   endtask

   // Hold the input idle until every owed result has been taken.
   task automatic wait_for_results();
      int guard;
      guard = 0;
      req_valid <= 1'b0;
      @(posedge clock);
      while (decoder_check.pending() != 0 && guard < 5000) begin
         @(posedge clock);
         guard++;
      end
      if (decoder_check.pending() != 0) begin
         $display("%0d expected results never arrived", decoder_check.pending());
         decoder_check.errors += decoder_check.pending();
         decoder_check.results_due.delete();
      end
      repeat (4) @(posedge clock);
   endtask

   function automatic void put_seq(ref octet_queue_type s, input logic [20:0] v,
                                   input int n);
      case (n)
         1: s.insert(s.size(), {1'b0, v[6:0]});
         2: s.insert(s.size(), {3'b110, v[10:6]});
         3: s.insert(s.size(), {4'b1110, v[15:12]});
         default: s.insert(s.size(), {5'b11110, v[20:18]});
      endcase
      for (int k = n - 2; k >= 0; k--) begin
         s.insert(s.size(), {2'b10, v[6*k +: 6]});
      end
   endfunction

   // Mostly well-formed sequences, with some malformed ones and raw noise.
   task automatic send_random_string();
      octet_queue_type s;
      int     nseq;
      int     kind;
      int     n;
      logic [20:0] v;
      nseq = $urandom_range(1, 8);
      for (int i = 0; i < nseq; i++) begin
         kind = $urandom_range(99);
         if (kind < 35) begin
            put_seq(s, 21'($urandom_range(0, 127)), 1);
         end else if (kind < 50) begin
            put_seq(s, 21'($urandom_range(21'h80, 21'h7FF)), 2);
         end else if (kind < 62) begin
            put_seq(s, 21'($urandom_range(21'h800, 21'hFFFF)), 3);
         end else if (kind < 72) begin
            put_seq(s, 21'($urandom_range(21'h10000, 21'h10FFFF)), 4);
         end else if (kind < 76) begin
            n = $urandom_range(2, 4);
            v = (n == 2) ? utf8dv_pkg::MinLen2 :
                (n == 3) ? utf8dv_pkg::MinLen3 : utf8dv_pkg::MinLen4;
            put_seq(s, 21'($urandom_range(0, v - 1)), n);
         end else if (kind < 79) begin
            put_seq(s, 21'($urandom_range(utf8dv_pkg::SurrLo, utf8dv_pkg::SurrHi)), 3);
         end else if (kind < 82) begin
            put_seq(s, 21'($urandom_range(21'h110000, 21'h1FFFFF)), 4);
         end else if (kind < 88) begin
            n = $urandom_range(2, 4);
            put_seq(s, 21'($urandom_range(utf8dv_pkg::MinLen3, utf8dv_pkg::CpMax)), n);
            // cut the tail or corrupt one continuation byte
            if ($urandom_range(1)) begin
               void'(s.pop_back());
            end else begin
               s[s.size() - 1 - $urandom_range(0, n - 2)] = 8'($urandom_range(0, 255));
            end
         end else begin
            s.insert(s.size(), 8'($urandom_range(0, 255)));
         end
      end
      send_string(s);
   endtask

   initial begin
      octet_queue_type str;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ASCII extremes
      str = '{8'h00, 8'h7F};
      send_string(str);
      // smallest two-byte value, then largest scalar value
      str = '{8'hC2, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
      send_string(str);
      // overlong through a C0 lead
      str = '{8'hC0, 8'h80};
      send_string(str);
      // surrogate
      str = '{8'hED, 8'hA0, 8'h80};
      send_string(str);
      // beyond range, then a byte dropped at the end of the string
      str = '{8'hF4, 8'h90, 8'h80, 8'h80, 8'h41};
      send_string(str);
      // bad continuation
      str = '{8'hC2, 8'h41};
      send_string(str);
      // sequence left open by the last byte
      str = '{8'hE2, 8'h82};
      send_string(str);
      str = '{8'hF0};
      send_string(str);
      // bad lead
      str = '{8'hFF};
      send_string(str);
      wait_for_results();

      // back-to-back stretch with no idling on either side
      idle_pct = 0;
      while (bytes_sent < 350) begin
         send_random_string();
      end
      idle_pct = 13;
      while (bytes_sent < 1325) begin
         send_random_string();
         if ($urandom_range(29) == 0) begin
            wait_for_results();
         end
      end
      wait_for_results();

      $display("Sent %0d bytes in %0d strings, gaps and back-pressure on both sides.",
               bytes_sent, strings_sent);
      $display("Checked %0d results; %0d strings ended valid.",
               decoder_check.checked, decoder_check.good_strings);
      if (decoder_check.errors == 0) begin
         $display("utf8_stream_decoder_validator_tb: clean");
      end else begin
         $display("utf8_stream_decoder_validator_tb: errors");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("timeout waiting on the decoder");
      $display("utf8_stream_decoder_validator_tb: errors");
      $finish;
   end

endmodule
